// ===== rtl/core/dmac_pkg.sv =====
`timescale 1ns / 1ps

package dmac_pkg;

	// Default sizes of the windows and of the price word.
	localparam int unsigned MAX_FAST_DEF   = 32;
	localparam int unsigned MAX_SLOW_DEF   = 64;
	localparam int unsigned PRICE_BITS_DEF = 32;

	// Fixed port field widths.
	localparam int unsigned PRICE_W       = 32;
	localparam int unsigned AVG_W         = 32;
	localparam int unsigned SIG_W         = 2;
	localparam int unsigned FAST_PERIOD_W = 6;
	localparam int unsigned SLOW_PERIOD_W = 7;
	localparam int unsigned CFG_INDEX_W   = 2;
	localparam int unsigned CFG_DATA_W    = 7;

	// Output word: fast_avg, slow_avg, signal, padded to whole bytes.
	localparam int unsigned OUT_FIELDS_W = 2 * AVG_W + SIG_W;
	localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	localparam logic [FAST_PERIOD_W-1:0] FAST_PERIOD_RST = 6'd10;
	localparam logic [SLOW_PERIOD_W-1:0] SLOW_PERIOD_RST = 7'd30;

	// Register indexes on the configuration channel.
	localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD = 2'd1;

	// Crossover codes.
	typedef logic [SIG_W-1:0] sig_t;
	localparam sig_t SIG_NONE = 2'd0;
	localparam sig_t SIG_UP   = 2'd1;
	localparam sig_t SIG_DOWN = 2'd2;

	// Control from the sequencer to each window.
	typedef struct packed {
		logic clear;
		logic push;
	} win_ctl_t;

endpackage

// ===== rtl/core/dmac_ram.sv =====
`timescale 1ns / 1ps

module dmac_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/dmac_window.sv =====
`timescale 1ns / 1ps

module dmac_window #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned PB    = 32,
	parameter int unsigned PW    = 7,
	parameter int unsigned BW    = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dmac_pkg::win_ctl_t              ctl,
	input  logic [PB-1:0]                   price,
	input  logic [PW-1:0]                   period,
	input  logic [BW-1:0]                   bars,
	output logic [PB+$clog2(DEPTH)-1:0]     total
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned TW = PB + AW;

	logic [AW-1:0] pos_q;
	logic [TW-1:0] total_q;
	logic [PB-1:0] rdata;
	logic [PB-1:0] old_price;
	logic [AW:0]   pos_inc;

	dmac_ram #(
		.WIDTH(PB),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(pos_q),
		.wdata(price),
		.raddr(pos_q),
		.rdata(rdata)
	);

	// Slots are filled in order from zero, so a slot is written once more bars
	// than its index have been pushed since the last clear.
	assign old_price = (32'(bars) > 32'(pos_q)) ? rdata : '0;
	assign pos_inc   = {1'b0, pos_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			total_q <= '0;
		end else if (ctl.clear) begin
			pos_q   <= '0;
			total_q <= '0;
		end else if (ctl.push) begin
			total_q <= total_q - TW'(old_price) + TW'(price);
			if (32'(pos_inc) >= 32'(period)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[AW-1:0];
			end
		end
	end

	assign total = total_q;

endmodule

// ===== rtl/core/dmac_div.sv =====
`timescale 1ns / 1ps

module dmac_div #(
	parameter int unsigned NW = 38,
	parameter int unsigned DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient,
	output logic          busy
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] dq_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_nxt;
	logic          qbit;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// at the top while quotient bits shift in at the bottom.
	always_comb begin
		trial = {rem_q, dq_q[NW-1]};
		diff  = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_nxt = diff[DW-1:0];
			qbit    = 1'b1;
		end else begin
			rem_nxt = trial[DW-1:0];
			qbit    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[NW-2:0], qbit};
		end
	end

	assign quotient = dq_q;
	assign busy     = busy_q;

endmodule

// ===== rtl/core/dual_moving_average_crossover_core.sv =====
`timescale 1ns / 1ps

// Moving-average crossover detector. Each price word on the s_ side enters a
// fast and a slow circular window whose running sums are divided by the
// configured periods; every bar gives one m_ word with both averages, the
// crossover code and, on m_tuser, a flag that both windows are full. A result
// word is built in steps after its price is taken: a window memory read, the
// sum update, the divider load, one quotient bit per cycle over the slow sum's
// width with the two bit-serial dividers running side by side, a state to see
// them finish, and the result stage. The next price is taken only once that
// word has moved into the output register, so the core holds one bar at a
// time and waits while the output does not drain. A finished word waits in
// the output register while the next price is taken. Writing either period
// register clears all window state; writes are taken only between bars.
module dual_moving_average_crossover_core #(
	parameter int unsigned MAX_FAST   = dmac_pkg::MAX_FAST_DEF,
	parameter int unsigned MAX_SLOW   = dmac_pkg::MAX_SLOW_DEF,
	parameter int unsigned PRICE_BITS = dmac_pkg::PRICE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dmac_pkg::PRICE_W-1:0]       s_tdata,  // price
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dmac_pkg::OUT_DATA_W-1:0]    m_tdata,  // fast_avg, slow_avg, signal, zeros
	output logic                               m_tuser,  // avg_valid
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dmac_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dmac_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned FPW     = $clog2(MAX_FAST + 1);
	localparam int unsigned SPW     = $clog2(MAX_SLOW + 1);
	localparam int unsigned FTW     = PRICE_BITS + $clog2(MAX_FAST);
	localparam int unsigned STW     = PRICE_BITS + $clog2(MAX_SLOW);
	localparam int unsigned BAR_CAP = (MAX_FAST > MAX_SLOW) ? MAX_FAST : MAX_SLOW;
	localparam int unsigned BW      = $clog2(BAR_CAP + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_SUM  = 6'b000100,
		ST_LOAD = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t                                  state_q;
	logic [dmac_pkg::FAST_PERIOD_W-1:0]      fast_period_q;
	logic [dmac_pkg::SLOW_PERIOD_W-1:0]      slow_period_q;
	logic [PRICE_BITS-1:0]                   price_q;
	logic [BW-1:0]                           bars_q;
	logic [PRICE_BITS-1:0]                   prev_fast_q;
	logic [PRICE_BITS-1:0]                   prev_slow_q;
	logic                                    prev_valid_q;
	logic                                    m_tvalid_q;
	logic [dmac_pkg::AVG_W-1:0]              fast_avg_q;
	logic [dmac_pkg::AVG_W-1:0]              slow_avg_q;
	logic                                    avg_valid_q;
	dmac_pkg::sig_t                          signal_q;

	logic [FPW-1:0]        fast_p;
	logic [SPW-1:0]        slow_p;
	logic                  cfg_wr;
	logic                  clear;
	logic                  in_acc;
	logic                  out_free;
	logic                  load_out;
	dmac_pkg::win_ctl_t    win_ctl;
	logic [FTW-1:0]        fast_total;
	logic [STW-1:0]        slow_total;
	logic [FTW-1:0]        fast_quot;
	logic [STW-1:0]        slow_quot;
	logic                  fast_busy;
	logic                  slow_busy;
	logic                  div_start;
	logic                  fast_ok;
	logic                  slow_ok;
	logic                  both_ok;
	logic [PRICE_BITS-1:0] fast_avg;
	logic [PRICE_BITS-1:0] slow_avg;
	dmac_pkg::sig_t        signal;

	// A period of zero acts as one; a period above the window depth acts as
	// the depth.
	always_comb begin
		if (fast_period_q == '0) begin
			fast_p = FPW'(1);
		end else if (32'(fast_period_q) > 32'(MAX_FAST)) begin
			fast_p = FPW'(MAX_FAST);
		end else begin
			fast_p = FPW'(fast_period_q);
		end
		if (slow_period_q == '0) begin
			slow_p = SPW'(1);
		end else if (32'(slow_period_q) > 32'(MAX_SLOW)) begin
			slow_p = SPW'(MAX_SLOW);
		end else begin
			slow_p = SPW'(slow_period_q);
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign clear     = cfg_wr && (cfg_index == dmac_pkg::CFG_FAST_PERIOD ||
		cfg_index == dmac_pkg::CFG_SLOW_PERIOD);
	assign out_free  = !m_tvalid_q || m_tready;
	assign load_out  = (state_q == ST_DONE) && out_free;
	assign div_start = (state_q == ST_LOAD);

	assign win_ctl.clear = clear;
	assign win_ctl.push  = (state_q == ST_SUM);

	dmac_window #(
		.DEPTH(MAX_FAST),
		.PB   (PRICE_BITS),
		.PW   (FPW),
		.BW   (BW)
	) u_fast_win (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.price (price_q),
		.period(fast_p),
		.bars  (bars_q),
		.total (fast_total)
	);

	dmac_window #(
		.DEPTH(MAX_SLOW),
		.PB   (PRICE_BITS),
		.PW   (SPW),
		.BW   (BW)
	) u_slow_win (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.price (price_q),
		.period(slow_p),
		.bars  (bars_q),
		.total (slow_total)
	);

	dmac_div #(
		.NW(FTW),
		.DW(FPW)
	) u_fast_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(fast_total),
		.divisor (fast_p),
		.quotient(fast_quot),
		.busy    (fast_busy)
	);

	dmac_div #(
		.NW(STW),
		.DW(SPW)
	) u_slow_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(slow_total),
		.divisor (slow_p),
		.quotient(slow_quot),
		.busy    (slow_busy)
	);

	// The average of a window never exceeds the largest price, so the low
	// price-width bits of the quotient hold it whole.
	assign fast_ok  = 32'(bars_q) >= 32'(fast_p);
	assign slow_ok  = 32'(bars_q) >= 32'(slow_p);
	assign both_ok  = fast_ok && slow_ok;
	assign fast_avg = fast_ok ? fast_quot[PRICE_BITS-1:0] : '0;
	assign slow_avg = slow_ok ? slow_quot[PRICE_BITS-1:0] : '0;

	always_comb begin
		signal = dmac_pkg::SIG_NONE;
		if (both_ok && prev_valid_q) begin
			if (prev_fast_q <= prev_slow_q && fast_avg > slow_avg) begin
				signal = dmac_pkg::SIG_UP;
			end else if (prev_fast_q >= prev_slow_q && fast_avg < slow_avg) begin
				signal = dmac_pkg::SIG_DOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (!fast_busy && !slow_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_period_q <= dmac_pkg::FAST_PERIOD_RST;
			slow_period_q <= dmac_pkg::SLOW_PERIOD_RST;
			bars_q        <= '0;
			prev_fast_q   <= '0;
			prev_slow_q   <= '0;
			prev_valid_q  <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (clear) begin
				bars_q       <= '0;
				prev_fast_q  <= '0;
				prev_slow_q  <= '0;
				prev_valid_q <= 1'b0;
				if (cfg_index == dmac_pkg::CFG_FAST_PERIOD) begin
					fast_period_q <= cfg_data[dmac_pkg::FAST_PERIOD_W-1:0];
				end else begin
					slow_period_q <= cfg_data[dmac_pkg::SLOW_PERIOD_W-1:0];
				end
			end
			if (state_q == ST_SUM && 32'(bars_q) < 32'(BAR_CAP)) begin
				bars_q <= bars_q + 1'b1;
			end
			if (load_out) begin
				prev_fast_q  <= fast_avg;
				prev_slow_q  <= slow_avg;
				prev_valid_q <= both_ok;
				m_tvalid_q   <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			price_q <= PRICE_BITS'(s_tdata);
		end
		if (load_out) begin
			fast_avg_q  <= dmac_pkg::AVG_W'(fast_avg);
			slow_avg_q  <= dmac_pkg::AVG_W'(slow_avg);
			avg_valid_q <= both_ok;
			signal_q    <= signal;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{dmac_pkg::OUT_PAD_W{1'b0}}, signal_q, slow_avg_q, fast_avg_q};
	assign m_tuser  = avg_valid_q;

endmodule
